### rtl/i2ceb_pkg.sv
// Shared types, register indexes and constants of the I2C EEPROM byte master.
package i2ceb_pkg;

	localparam int DELAY_WIDTH_DEF = 20;
	localparam int DEV_W           = 7;
	localparam int SHORT_W         = 12;
	localparam int WAIT_W          = 20;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = WAIT_W;
	localparam int IN_DATA_W       = 24;
	localparam int OUT_DATA_W      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_DELAY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_DELAY     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_WAIT     = 2'd3;

	localparam logic [DEV_W-1:0]   DEV_ADDR_RST   = 7'd80;
	localparam logic [SHORT_W-1:0] SHORT_DLY_RST  = 12'd2;
	localparam logic [SHORT_W-1:0] LONG_DLY_RST   = 12'd5;
	localparam logic [WAIT_W-1:0]  WRITE_WAIT_RST = 20'd10000;

	localparam logic [7:0] READ_FAIL_BYTE = 8'hFF;

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_HIGH, PH_ST_LOW, PH_TX_LOW1, PH_TX_LOW2, PH_TX_HIGH,
		PH_ACK_LOW1, PH_ACK_LOW2, PH_ACK_HIGH, PH_RX_LOW, PH_RX_HIGH,
		PH_NK_LOW1, PH_NK_LOW2, PH_NK_HIGH, PH_GAP_RS, PH_GAP_SP,
		PH_SP_HIGH, PH_SP_REL, PH_WAIT
	} phase_t;

	typedef struct packed {
		logic [DEV_W-1:0]   device_address;
		logic [SHORT_W-1:0] short_delay_ticks;
		logic [SHORT_W-1:0] long_delay_ticks;
		logic [WAIT_W-1:0]  write_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic       start_request;
		logic       mode;
		logic [7:0] mem_address;
		logic [7:0] write_byte;
		logic       sda_sample;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic       success;
		logic [7:0] read_byte;
	} res_t;

endpackage

### rtl/i2ceb_cfg.sv
// Configuration register file of the I2C EEPROM byte master.
module i2ceb_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [i2ceb_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [i2ceb_pkg::CFG_DATA_W-1:0]    wr_data,
	output i2ceb_pkg::cfg_t                     cfg
);

	i2ceb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address    <= i2ceb_pkg::DEV_ADDR_RST;
			cfg_q.short_delay_ticks <= i2ceb_pkg::SHORT_DLY_RST;
			cfg_q.long_delay_ticks  <= i2ceb_pkg::LONG_DLY_RST;
			cfg_q.write_wait_ticks  <= i2ceb_pkg::WRITE_WAIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				i2ceb_pkg::REG_DEVICE_ADDRESS:
					cfg_q.device_address <= wr_data[i2ceb_pkg::DEV_W-1:0];
				i2ceb_pkg::REG_SHORT_DELAY:
					cfg_q.short_delay_ticks <= wr_data[i2ceb_pkg::SHORT_W-1:0];
				i2ceb_pkg::REG_LONG_DELAY:
					cfg_q.long_delay_ticks <= wr_data[i2ceb_pkg::SHORT_W-1:0];
				i2ceb_pkg::REG_WRITE_WAIT:
					cfg_q.write_wait_ticks <= wr_data[i2ceb_pkg::WAIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/i2ceb_seq.sv
// Bus sequencer: advances the I2C state by one tick per item and forms the result.
module i2ceb_seq #(
	parameter int DELAY_WIDTH = i2ceb_pkg::DELAY_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  i2ceb_pkg::cfg_t   cfg,
	input  i2ceb_pkg::item_t  item,
	output i2ceb_pkg::res_t   res
);

	localparam int WIDE_W = 33;

	i2ceb_pkg::phase_t phase_q, phase_d;
	logic [3:0]             bit_cnt_q, bit_cnt_d;
	logic [3:0]             bit_inc;
	logic [7:0]             shift_q, shift_d;
	logic [DELAY_WIDTH-1:0] delay_q, delay_d;
	logic                   mode_q, mode_d;
	logic [7:0]             addr_q, addr_d;
	logic [7:0]             data_q, data_d;
	logic                   scl_q, scl_d;
	logic                   sda_q, sda_d;
	logic [1:0]             byte_idx_q, byte_idx_d;
	logic                   acked_q, acked_d;
	logic                   done;
	logic [DELAY_WIDTH-1:0] dly_s, dly_l, dly_w;
	logic [7:0]             dev_byte;

	// Delay values are clamped to the counter range and a zero counts as one tick.
	function automatic logic [DELAY_WIDTH-1:0] sat_dly(input logic [i2ceb_pkg::WAIT_W-1:0] n);
		logic [WIDE_W-1:0] wide;
		logic [WIDE_W-1:0] lim;
		begin
			wide = {{(WIDE_W-i2ceb_pkg::WAIT_W){1'b0}}, n};
			lim  = (WIDE_W'(1) << DELAY_WIDTH) - WIDE_W'(1);
			if (wide > lim)
				wide = lim;
			if (wide == '0)
				wide = WIDE_W'(1);
			return wide[DELAY_WIDTH-1:0];
		end
	endfunction

	assign dly_s = sat_dly(i2ceb_pkg::WAIT_W'(cfg.short_delay_ticks));
	assign dly_l = sat_dly(i2ceb_pkg::WAIT_W'(cfg.long_delay_ticks));
	assign dly_w = sat_dly(cfg.write_wait_ticks);
	assign dev_byte = {cfg.device_address, (byte_idx_q != 2'd0)};
	assign bit_inc = bit_cnt_q + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= i2ceb_pkg::PH_IDLE;
			bit_cnt_q  <= '0;
			shift_q    <= '0;
			delay_q    <= '0;
			mode_q     <= 1'b0;
			addr_q     <= '0;
			data_q     <= '0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			byte_idx_q <= '0;
			acked_q    <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			bit_cnt_q  <= bit_cnt_d;
			shift_q    <= shift_d;
			delay_q    <= delay_d;
			mode_q     <= mode_d;
			addr_q     <= addr_d;
			data_q     <= data_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
			byte_idx_q <= byte_idx_d;
			acked_q    <= acked_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		bit_cnt_d  = bit_cnt_q;
		shift_d    = shift_q;
		delay_d    = delay_q;
		mode_d     = mode_q;
		addr_d     = addr_q;
		data_d     = data_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		byte_idx_d = byte_idx_q;
		acked_d    = acked_q;
		done       = 1'b0;

		if (phase_q == i2ceb_pkg::PH_IDLE) begin
			if (item.start_request) begin
				mode_d     = item.mode;
				addr_d     = item.mem_address;
				data_d     = item.write_byte;
				byte_idx_d = 2'd0;
				bit_cnt_d  = 4'd0;
				acked_d    = 1'b0;
				phase_d    = i2ceb_pkg::PH_ST_HIGH;
				scl_d      = 1'b1;
				sda_d      = 1'b1;
				delay_d    = dly_l;
			end
		end else if (delay_q > DELAY_WIDTH'(1)) begin
			delay_d = delay_q - DELAY_WIDTH'(1);
		end else begin
			unique case (phase_q)
				i2ceb_pkg::PH_ST_HIGH: begin
					phase_d = i2ceb_pkg::PH_ST_LOW;
					scl_d = 1'b1; sda_d = 1'b0; delay_d = dly_l;
				end
				i2ceb_pkg::PH_ST_LOW: begin
					shift_d = dev_byte; bit_cnt_d = 4'd0;
					phase_d = i2ceb_pkg::PH_TX_LOW1; scl_d = 1'b0; delay_d = dly_s;
				end
				i2ceb_pkg::PH_TX_LOW1: begin
					phase_d = i2ceb_pkg::PH_TX_LOW2;
					scl_d = 1'b0; sda_d = shift_q[7]; delay_d = dly_s;
					shift_d = {shift_q[6:0], 1'b0};
				end
				i2ceb_pkg::PH_TX_LOW2: begin
					phase_d = i2ceb_pkg::PH_TX_HIGH; scl_d = 1'b1; delay_d = dly_l;
				end
				i2ceb_pkg::PH_TX_HIGH: begin
					bit_cnt_d = bit_inc;
					phase_d = (bit_inc < 4'd8) ? i2ceb_pkg::PH_TX_LOW1 : i2ceb_pkg::PH_ACK_LOW1;
					scl_d = 1'b0; delay_d = dly_s;
				end
				i2ceb_pkg::PH_ACK_LOW1: begin
					phase_d = i2ceb_pkg::PH_ACK_LOW2;
					scl_d = 1'b0; sda_d = 1'b1; delay_d = dly_s;
				end
				i2ceb_pkg::PH_ACK_LOW2: begin
					phase_d = i2ceb_pkg::PH_ACK_HIGH;
					scl_d = 1'b1; sda_d = 1'b1; delay_d = dly_l;
				end
				i2ceb_pkg::PH_ACK_HIGH: begin
					sda_d = 1'b1;
					if (item.sda_sample) begin
						// Not acknowledged: straight to stop, transfer fails.
						acked_d = 1'b0;
						phase_d = i2ceb_pkg::PH_GAP_SP;
						scl_d = 1'b0; sda_d = 1'b0; delay_d = dly_s;
					end else if (byte_idx_q == 2'd0) begin
						byte_idx_d = 2'd1;
						shift_d = addr_q; bit_cnt_d = 4'd0;
						phase_d = i2ceb_pkg::PH_TX_LOW1; scl_d = 1'b0; delay_d = dly_s;
					end else if (byte_idx_q == 2'd1) begin
						byte_idx_d = 2'd2;
						if (!mode_q) begin
							shift_d = data_q; bit_cnt_d = 4'd0;
							phase_d = i2ceb_pkg::PH_TX_LOW1; scl_d = 1'b0; delay_d = dly_s;
						end else begin
							phase_d = i2ceb_pkg::PH_GAP_RS; scl_d = 1'b0; delay_d = dly_s;
						end
					end else if (!mode_q) begin
						acked_d = 1'b1;
						phase_d = i2ceb_pkg::PH_GAP_SP;
						scl_d = 1'b0; sda_d = 1'b0; delay_d = dly_s;
					end else begin
						bit_cnt_d = 4'd0; shift_d = 8'd0;
						phase_d = i2ceb_pkg::PH_RX_LOW; scl_d = 1'b0; delay_d = dly_s;
					end
				end
				i2ceb_pkg::PH_RX_LOW: begin
					phase_d = i2ceb_pkg::PH_RX_HIGH;
					scl_d = 1'b1; sda_d = 1'b1; delay_d = dly_l;
				end
				i2ceb_pkg::PH_RX_HIGH: begin
					shift_d = {shift_q[6:0], item.sda_sample};
					bit_cnt_d = bit_inc;
					phase_d = (bit_inc < 4'd8) ? i2ceb_pkg::PH_RX_LOW : i2ceb_pkg::PH_NK_LOW1;
					scl_d = 1'b0; sda_d = 1'b1; delay_d = dly_s;
				end
				i2ceb_pkg::PH_NK_LOW1: begin
					phase_d = i2ceb_pkg::PH_NK_LOW2;
					scl_d = 1'b0; sda_d = 1'b1; delay_d = dly_s;
				end
				i2ceb_pkg::PH_NK_LOW2: begin
					phase_d = i2ceb_pkg::PH_NK_HIGH;
					scl_d = 1'b1; sda_d = 1'b1; delay_d = dly_l;
				end
				i2ceb_pkg::PH_NK_HIGH: begin
					acked_d = 1'b1;
					phase_d = i2ceb_pkg::PH_GAP_SP;
					scl_d = 1'b0; sda_d = 1'b0; delay_d = dly_s;
				end
				i2ceb_pkg::PH_GAP_RS: begin
					phase_d = i2ceb_pkg::PH_ST_HIGH;
					scl_d = 1'b1; sda_d = 1'b1; delay_d = dly_l;
				end
				i2ceb_pkg::PH_GAP_SP: begin
					phase_d = i2ceb_pkg::PH_SP_HIGH;
					scl_d = 1'b1; sda_d = 1'b0; delay_d = dly_l;
				end
				i2ceb_pkg::PH_SP_HIGH: begin
					phase_d = i2ceb_pkg::PH_SP_REL;
					scl_d = 1'b1; sda_d = 1'b1; delay_d = dly_l;
				end
				i2ceb_pkg::PH_SP_REL: begin
					if (!mode_q && acked_q && (cfg.write_wait_ticks != '0)) begin
						phase_d = i2ceb_pkg::PH_WAIT;
						scl_d = 1'b1; sda_d = 1'b1; delay_d = dly_w;
					end else begin
						done = 1'b1;
					end
				end
				i2ceb_pkg::PH_WAIT: done = 1'b1;
				default: begin
					phase_d = i2ceb_pkg::PH_IDLE;
					scl_d = 1'b1; sda_d = 1'b1; delay_d = '0;
				end
			endcase
			if (done) begin
				phase_d = i2ceb_pkg::PH_IDLE;
				scl_d = 1'b1; sda_d = 1'b1; delay_d = '0;
			end
		end

		res.scl_level = scl_d;
		res.sda_level = sda_d;
		res.busy_res  = (phase_d != i2ceb_pkg::PH_IDLE);
		res.done_res  = done;
		res.success   = done & acked_d;
		if (done && mode_q)
			res.read_byte = acked_d ? shift_d : i2ceb_pkg::READ_FAIL_BYTE;
		else
			res.read_byte = 8'd0;
	end

endmodule

### rtl/i2c_eeprom_byte_master_core.sv
// Top level of the tick-driven I2C EEPROM single-byte master.
// Each input transfer is one bus timing tick and yields exactly one result transfer
// carrying the SCL/SDA drive for that tick, busy, a done pulse, success and the read
// byte. The block takes one item per clock cycle while the result side takes results;
// an item goes into the input register and, once the output slot is free, through
// the bus sequencer into the output register; the sequencer state is updated once
// per item. A transfer starts on a tick with start_request set while idle; its length
// in ticks follows from the delay registers, and a successful write adds
// write_wait_ticks before done. Configuration must be written through the cfg
// channel only while no item is in flight; the block itself does not enforce it.
module i2c_eeprom_byte_master_core #(
	parameter int DELAY_WIDTH = i2ceb_pkg::DELAY_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// start_request[0], mem_address[8:1], write_byte[16:9], sda_sample[17], zero pad
	input  logic [i2ceb_pkg::IN_DATA_W-1:0]      s_tdata,
	// mode[0]
	input  logic                                 s_tuser,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// scl_level[0], sda_level[1], busy_res[2], done_res[3], success[4],
	// read_byte[12:5], zero pad
	output logic [i2ceb_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [i2ceb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [i2ceb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	i2ceb_pkg::cfg_t  cfg;
	i2ceb_pkg::item_t item_s1;
	i2ceb_pkg::res_t  res;
	logic             valid_s1;
	logic             out_free;
	logic             step;
	logic [i2ceb_pkg::OUT_DATA_W-1:0] tdata_q;
	logic             tvalid_q;

	assign cfg_ready = 1'b1;

	i2ceb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The output slot is free when empty or being taken this cycle.
	assign out_free = !tvalid_q || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.start_request <= s_tdata[0];
			item_s1.mode          <= s_tuser;
			item_s1.mem_address   <= s_tdata[8:1];
			item_s1.write_byte    <= s_tdata[16:9];
			item_s1.sda_sample    <= s_tdata[17];
		end
	end

	i2ceb_seq #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (out_free) begin
			tvalid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			tdata_q <= {3'd0, res.read_byte, res.success, res.done_res, res.busy_res,
				res.sda_level, res.scl_level};
		end
	end

	assign m_tdata  = tdata_q;
	assign m_tvalid = tvalid_q;

endmodule

### rtl/i2ceb_chk.sv
// Port-level checker of the I2C EEPROM byte master, bound to the top level.
module i2ceb_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic [i2ceb_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready
);

	// A finished transfer leaves the block idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3]) |-> !m_tdata[2])
		else $error("done reported while still busy");

	// Success and read byte carry nothing outside the done pulse.
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[3]) |-> (m_tdata[12:4] == 9'd0))
		else $error("success or read byte set without done");

	// When idle the bus lines are released.
	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[2]) |-> (m_tdata[0] && m_tdata[1]))
		else $error("bus driven low while idle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result transfer changed");

endmodule

bind i2c_eeprom_byte_master_core i2ceb_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

### verif/i2ceb_tick_checker.sv
// Watches the channels of the I2C EEPROM byte master, predicts every result and compares.
module i2ceb_tick_checker #(
	parameter int DELAY_WIDTH = i2ceb_pkg::DELAY_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [i2ceb_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                 s_tuser,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [i2ceb_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [i2ceb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [i2ceb_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                   mismatches,
	output int                                   pending
);

	localparam longint unsigned SEG_MAX = (longint'(1) << DELAY_WIDTH) - 1;

	// Shadow of the bus sequencer and its registers.
	i2ceb_pkg::cfg_t   regs;
	i2ceb_pkg::phase_t seq_ph;
	logic [3:0]        bit_no;
	logic [7:0]        sh;
	longint unsigned   seg_left;
	logic              mode_q;
	logic [7:0]        addr_q;
	logic [7:0]        data_q;
	logic              scl_q;
	logic              sda_q;
	logic [1:0]        byte_no;
	logic              all_acked;

	i2ceb_pkg::res_t   tick_results_q [$];
	i2ceb_pkg::res_t   want;
	i2ceb_pkg::res_t   got;
	i2ceb_pkg::item_t  tick_in;
	logic [5:0]        diff;
	int                results_seen;

	function automatic void hold_levels(i2ceb_pkg::phase_t ph, logic scl, logic sda,
			longint unsigned ticks);
		longint unsigned n;
		n = ticks;
		if (n > SEG_MAX)
			n = SEG_MAX;
		if (n == 0)
			n = 1;
		seq_ph = ph;
		scl_q = scl;
		sda_q = sda;
		seg_left = n;
	endfunction

	function automatic void load_byte(logic [7:0] value);
		sh = value;
		bit_no = '0;
		hold_levels(i2ceb_pkg::PH_TX_LOW1, 1'b0, sda_q, regs.short_delay_ticks);
	endfunction

	// Closes the current bus segment; returns 1 when the bus access is over.
	function automatic bit end_segment(logic sda_in);
		longint unsigned sd;
		longint unsigned ld;
		sd = regs.short_delay_ticks;
		ld = regs.long_delay_ticks;
		case (seq_ph)
			i2ceb_pkg::PH_ST_HIGH: hold_levels(i2ceb_pkg::PH_ST_LOW, 1'b1, 1'b0, ld);
			i2ceb_pkg::PH_ST_LOW: load_byte({regs.device_address, byte_no != 0});
			i2ceb_pkg::PH_TX_LOW1: begin
				hold_levels(i2ceb_pkg::PH_TX_LOW2, 1'b0, sh[7], sd);
				sh = {sh[6:0], 1'b0};
			end
			i2ceb_pkg::PH_TX_LOW2: hold_levels(i2ceb_pkg::PH_TX_HIGH, 1'b1, sda_q, ld);
			i2ceb_pkg::PH_TX_HIGH: begin
				bit_no = bit_no + 1'b1;
				if (bit_no < 8)
					hold_levels(i2ceb_pkg::PH_TX_LOW1, 1'b0, sda_q, sd);
				else
					hold_levels(i2ceb_pkg::PH_ACK_LOW1, 1'b0, sda_q, sd);
			end
			i2ceb_pkg::PH_ACK_LOW1: hold_levels(i2ceb_pkg::PH_ACK_LOW2, 1'b0, 1'b1, sd);
			i2ceb_pkg::PH_ACK_LOW2: hold_levels(i2ceb_pkg::PH_ACK_HIGH, 1'b1, 1'b1, ld);
			i2ceb_pkg::PH_ACK_HIGH: begin
				sda_q = 1'b1;
				if (sda_in) begin
					all_acked = 1'b0;
					hold_levels(i2ceb_pkg::PH_GAP_SP, 1'b0, 1'b0, sd);
				end else if (byte_no == 0) begin
					byte_no = 2'd1;
					load_byte(addr_q);
				end else if (byte_no == 1) begin
					byte_no = 2'd2;
					if (!mode_q)
						load_byte(data_q);
					else
						hold_levels(i2ceb_pkg::PH_GAP_RS, 1'b0, 1'b1, sd);
				end else if (!mode_q) begin
					all_acked = 1'b1;
					hold_levels(i2ceb_pkg::PH_GAP_SP, 1'b0, 1'b0, sd);
				end else begin
					bit_no = '0;
					sh = '0;
					hold_levels(i2ceb_pkg::PH_RX_LOW, 1'b0, 1'b1, sd);
				end
			end
			i2ceb_pkg::PH_RX_LOW: hold_levels(i2ceb_pkg::PH_RX_HIGH, 1'b1, 1'b1, ld);
			i2ceb_pkg::PH_RX_HIGH: begin
				sh = {sh[6:0], sda_in};
				bit_no = bit_no + 1'b1;
				if (bit_no < 8)
					hold_levels(i2ceb_pkg::PH_RX_LOW, 1'b0, 1'b1, sd);
				else
					hold_levels(i2ceb_pkg::PH_NK_LOW1, 1'b0, 1'b1, sd);
			end
			i2ceb_pkg::PH_NK_LOW1: hold_levels(i2ceb_pkg::PH_NK_LOW2, 1'b0, 1'b1, sd);
			i2ceb_pkg::PH_NK_LOW2: hold_levels(i2ceb_pkg::PH_NK_HIGH, 1'b1, 1'b1, ld);
			i2ceb_pkg::PH_NK_HIGH: begin
				all_acked = 1'b1;
				hold_levels(i2ceb_pkg::PH_GAP_SP, 1'b0, 1'b0, sd);
			end
			i2ceb_pkg::PH_GAP_RS: hold_levels(i2ceb_pkg::PH_ST_HIGH, 1'b1, 1'b1, ld);
			i2ceb_pkg::PH_GAP_SP: hold_levels(i2ceb_pkg::PH_SP_HIGH, 1'b1, 1'b0, ld);
			i2ceb_pkg::PH_SP_HIGH: hold_levels(i2ceb_pkg::PH_SP_REL, 1'b1, 1'b1, ld);
			i2ceb_pkg::PH_SP_REL: begin
				// Only an acknowledged write waits out the EEPROM write cycle.
				if (!mode_q && all_acked && regs.write_wait_ticks != 0) begin
					hold_levels(i2ceb_pkg::PH_WAIT, 1'b1, 1'b1, regs.write_wait_ticks);
					return 1'b0;
				end
				return 1'b1;
			end
			i2ceb_pkg::PH_WAIT: return 1'b1;
			default: begin
				seq_ph = i2ceb_pkg::PH_IDLE;
				scl_q = 1'b1;
				sda_q = 1'b1;
				seg_left = 0;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic i2ceb_pkg::res_t sequence_tick(i2ceb_pkg::item_t it);
		i2ceb_pkg::res_t r;
		bit              finished;
		r = '0;
		finished = 1'b0;
		if (seq_ph == i2ceb_pkg::PH_IDLE) begin
			if (it.start_request) begin
				mode_q = it.mode;
				addr_q = it.mem_address;
				data_q = it.write_byte;
				byte_no = '0;
				bit_no = '0;
				all_acked = 1'b0;
				hold_levels(i2ceb_pkg::PH_ST_HIGH, 1'b1, 1'b1, regs.long_delay_ticks);
			end
		end else if (seg_left > 1) begin
			seg_left = seg_left - 1;
		end else if (end_segment(it.sda_sample)) begin
			finished = 1'b1;
			r.success = all_acked;
			if (mode_q)
				r.read_byte = all_acked ? sh : i2ceb_pkg::READ_FAIL_BYTE;
			seq_ph = i2ceb_pkg::PH_IDLE;
			scl_q = 1'b1;
			sda_q = 1'b1;
			seg_left = 0;
		end
		r.scl_level = scl_q;
		r.sda_level = sda_q;
		r.busy_res = seq_ph != i2ceb_pkg::PH_IDLE;
		r.done_res = finished;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.device_address = i2ceb_pkg::DEV_ADDR_RST;
			regs.short_delay_ticks = i2ceb_pkg::SHORT_DLY_RST;
			regs.long_delay_ticks = i2ceb_pkg::LONG_DLY_RST;
			regs.write_wait_ticks = i2ceb_pkg::WRITE_WAIT_RST;
			seq_ph = i2ceb_pkg::PH_IDLE;
			bit_no = '0;
			sh = '0;
			seg_left = 0;
			mode_q = 1'b0;
			addr_q = '0;
			data_q = '0;
			scl_q = 1'b1;
			sda_q = 1'b1;
			byte_no = '0;
			all_acked = 1'b0;
			tick_results_q.delete();
			results_seen = 0;
			mismatches = 0;
			pending = 0;
		end else begin
			// Results are checked before this edge's input is predicted, so a result
			// can never be matched against the item accepted at the same edge.
			if (m_tvalid && m_tready) begin
				got.scl_level = m_tdata[0];
				got.sda_level = m_tdata[1];
				got.busy_res = m_tdata[2];
				got.done_res = m_tdata[3];
				got.success = m_tdata[4];
				got.read_byte = m_tdata[12:5];
				results_seen++;
				if (tick_results_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d arrived with no prediction outstanding",
							results_seen);
				end else begin
					want = tick_results_q.pop_front();
					diff = {got.scl_level !== want.scl_level,
						got.sda_level !== want.sda_level,
						got.busy_res !== want.busy_res,
						got.done_res !== want.done_res,
						got.success !== want.success,
						got.read_byte !== want.read_byte};
					if (diff != 0) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d differs (scl sda busy done ok byte: %06b)",
								results_seen, diff);
							$display("  expected %0b %0b %0b %0b %0b %02h",
								want.scl_level, want.sda_level, want.busy_res,
								want.done_res, want.success, want.read_byte);
							$display("  got      %0b %0b %0b %0b %0b %02h",
								got.scl_level, got.sda_level, got.busy_res,
								got.done_res, got.success, got.read_byte);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				tick_in.start_request = s_tdata[0];
				tick_in.mode = s_tuser;
				tick_in.mem_address = s_tdata[8:1];
				tick_in.write_byte = s_tdata[16:9];
				tick_in.sda_sample = s_tdata[17];
				tick_results_q.push_back(sequence_tick(tick_in));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					i2ceb_pkg::REG_DEVICE_ADDRESS:
						regs.device_address = cfg_data[i2ceb_pkg::DEV_W-1:0];
					i2ceb_pkg::REG_SHORT_DELAY:
						regs.short_delay_ticks = cfg_data[i2ceb_pkg::SHORT_W-1:0];
					i2ceb_pkg::REG_LONG_DELAY:
						regs.long_delay_ticks = cfg_data[i2ceb_pkg::SHORT_W-1:0];
					i2ceb_pkg::REG_WRITE_WAIT:
						regs.write_wait_ticks = cfg_data[i2ceb_pkg::WAIT_W-1:0];
					default: ;
				endcase
			end
			pending = tick_results_q.size();
		end
	end

endmodule

### verif/tb_i2c_eeprom_byte_master_core.sv
// Stimulus and verdict for the I2C EEPROM byte master, with the tick checker alongside.
module tb_i2c_eeprom_byte_master_core;

	localparam int CYCLE_LIMIT = 100000;
	localparam int HOLD_CYCLES = 400;

	// How the simulated EEPROM answers on SDA over a stretch of ticks.
	typedef enum {SDA_ACK, SDA_NACK, SDA_NOISY, SDA_COIN} sda_style_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic [i2ceb_pkg::IN_DATA_W-1:0]      s_tdata = '0;
	logic                                 s_tuser = 1'b0;
	logic                                 s_tvalid = 1'b0;
	logic                                 s_tready;
	logic [i2ceb_pkg::OUT_DATA_W-1:0]     m_tdata;
	logic                                 m_tvalid;
	logic                                 m_tready = 1'b0;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [i2ceb_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [i2ceb_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
	int                                   mismatches;
	int                                   pending;

	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          holds_asked = 0;
	int          holds_taken = 0;
	int          hold_cnt = 0;
	int          cycles = 0;
	int unsigned cur_short = i2ceb_pkg::SHORT_DLY_RST;
	int unsigned cur_long = i2ceb_pkg::LONG_DLY_RST;
	int unsigned cur_wait = i2ceb_pkg::WRITE_WAIT_RST;
	sda_style_t  sda_style = SDA_ACK;

	i2c_eeprom_byte_master_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	i2ceb_tick_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.m_tdata    (m_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("i2c_eeprom_byte_master_core regression: fail");
			$finish;
		end
	end

	// Result side: random back-pressure, plus a long hold whenever one is asked for.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cnt <= 0;
		end else if (holds_taken != holds_asked) begin
			holds_taken <= holds_asked;
			hold_cnt <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (hold_cnt != 0)
				hold_cnt <= hold_cnt - 1;
			m_tready <= (hold_cnt <= 1) && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic logic sda_level_for(sda_style_t st);
		case (st)
			SDA_ACK: return 1'b0;
			SDA_NACK: return 1'b1;
			SDA_NOISY: return $urandom_range(15) == 0;
			default: return 1'($urandom_range(1));
		endcase
	endfunction

	task automatic send_tick(input i2ceb_pkg::item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, it.sda_sample, it.write_byte, it.mem_address, it.start_request};
		s_tuser <= it.mode;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops offering items and waits until every predicted result has been taken.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic put_reg(input logic [i2ceb_pkg::CFG_IDX_W-1:0] idx,
			input logic [i2ceb_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_regs(input logic [i2ceb_pkg::DEV_W-1:0] dev, input int unsigned sd,
			input int unsigned ld, input int unsigned ww);
		drain();
		put_reg(i2ceb_pkg::REG_DEVICE_ADDRESS, i2ceb_pkg::CFG_DATA_W'(dev));
		put_reg(i2ceb_pkg::REG_SHORT_DELAY, i2ceb_pkg::CFG_DATA_W'(sd));
		put_reg(i2ceb_pkg::REG_LONG_DELAY, i2ceb_pkg::CFG_DATA_W'(ld));
		put_reg(i2ceb_pkg::REG_WRITE_WAIT, i2ceb_pkg::CFG_DATA_W'(ww));
		cfg_valid <= 1'b0;
		cur_short = sd;
		cur_long = ld;
		cur_wait = ww;
	endtask

	task automatic random_regs();
		load_regs(i2ceb_pkg::DEV_W'($urandom_range(127)), $urandom_range(3),
			$urandom_range(4), ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 1));
	endtask

	// One bus access: a request on the first tick, then enough ticks to see it through
	// (segs bus segments of the longest delay). Later ticks carry fresh field values,
	// which must not disturb the latched ones; with keep_asking the request stays set.
	task automatic run_access(input logic mode, input logic [7:0] addr,
			input logic [7:0] data, input sda_style_t style, input bit keep_asking,
			input int unsigned segs, input bit with_wait);
		i2ceb_pkg::item_t it;
		int unsigned      seg_len;
		int unsigned      span;
		seg_len = (cur_short > cur_long) ? cur_short : cur_long;
		if (seg_len == 0)
			seg_len = 1;
		span = segs * seg_len + (with_wait ? cur_wait : 0) + 8;
		for (int unsigned i = 0; i < span; i++) begin
			it.start_request = (i == 0) || keep_asking;
			it.mode = (i == 0) ? mode : 1'($urandom_range(1));
			it.mem_address = (i == 0) ? addr : 8'($urandom_range(255));
			it.write_byte = (i == 0) ? data : 8'($urandom_range(255));
			it.sda_sample = sda_level_for(style);
			send_tick(it);
		end
	endtask

	task automatic random_ticks(input int n);
		i2ceb_pkg::item_t it;
		int               w;
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0) begin
				w = $urandom_range(99);
				if (w < 30)
					sda_style = SDA_ACK;
				else if (w < 70)
					sda_style = SDA_NOISY;
				else if (w < 90)
					sda_style = SDA_COIN;
				else
					sda_style = SDA_NACK;
			end
			it.start_request = $urandom_range(2) == 0;
			it.mode = 1'($urandom_range(1));
			it.mem_address = 8'($urandom_range(255));
			it.write_byte = 8'($urandom_range(255));
			it.sda_sample = sda_level_for(sda_style);
			send_tick(it);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 28;
		rx_idle_pct = 61;

		// Register values after reset: a complete read with every byte acknowledged.
		run_access(1'b1, 8'h00, 8'hFF, SDA_ACK, 1'b0, 72, 1'b0);

		// Zero delays behave as one tick and a zero write wait skips the wait.
		load_regs(7'd0, 0, 0, 0);
		run_access(1'b0, 8'hFF, 8'h00, SDA_ACK, 1'b1, 120, 1'b0);
		run_access(1'b1, 8'h00, 8'h5A, SDA_ACK, 1'b0, 120, 1'b0);
		run_access(1'b1, 8'hFF, 8'hA5, SDA_COIN, 1'b0, 120, 1'b0);
		run_access(1'b1, 8'h3C, 8'h00, SDA_NACK, 1'b0, 40, 1'b0);
		run_access(1'b0, 8'hC3, 8'hFF, SDA_NACK, 1'b0, 40, 1'b0);

		load_regs(7'd127, 1, 1, 1);
		run_access(1'b0, 8'h81, 8'h7E, SDA_ACK, 1'b0, 120, 1'b1);
		run_access(1'b1, 8'h7E, 8'h81, SDA_NOISY, 1'b1, 120, 1'b1);

		random_regs();
		random_ticks(250);

		tx_idle_pct = 61;
		rx_idle_pct = 28;
		random_regs();
		random_ticks(250);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_regs();
		random_ticks(80);
		// The result side holds off while items keep coming, so the input must stall.
		holds_asked++;
		random_ticks(80);
		drain();
		random_ticks(50);

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("i2c_eeprom_byte_master_core regression: pass");
		else
			$display("i2c_eeprom_byte_master_core regression: fail");
		$finish;
	end

endmodule
